[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file iirdf1_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset too.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/iirdf1_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iirdf1_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 18;
  localparam int FRAC_BITS  = 14;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + 4;
  localparam int RND_W      = ACC_W - FRAC_BITS;
  localparam int HIST_DEPTH = 3;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  localparam coef_t COEF_ONE = coef_t'(1 << FRAC_BITS);
  localparam acc_t  RND_HALF = acc_t'(1 << (FRAC_BITS - 1));

  localparam cfg_idx_t REG_FF_COEF_0 = 3'd0;
  localparam cfg_idx_t REG_FF_COEF_1 = 3'd1;
  localparam cfg_idx_t REG_FF_COEF_2 = 3'd2;
  localparam cfg_idx_t REG_FF_COEF_3 = 3'd3;
  localparam cfg_idx_t REG_FB_COEF_1 = 3'd4;
  localparam cfg_idx_t REG_FB_COEF_2 = 3'd5;
  localparam cfg_idx_t REG_FB_COEF_3 = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACC,
    ST_RND
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
  } mac_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/iirdf1_mac.sv]
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_mac (
  input  logic                clk,
  input  iirdf1_pkg::mac_ctl_t ctl,
  input  iirdf1_pkg::coef_t   coef,
  input  iirdf1_pkg::sample_t data,
  output iirdf1_pkg::sample_t y,
  output logic                sat
);

  iirdf1_pkg::prod_t mul;
  iirdf1_pkg::prod_t prod_r;
  iirdf1_pkg::acc_t  acc_r;
  iirdf1_pkg::acc_t  acc_nxt;
  iirdf1_pkg::acc_t  rnd_sum;
  logic signed [iirdf1_pkg::RND_W-1:0] rnd_q;
  logic ovf_pos;
  logic ovf_neg;

  assign mul = coef * data;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctl.acc_en) begin
      acc_nxt = acc_r + iirdf1_pkg::acc_t'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= mul;
    end
    acc_r <= acc_nxt;
  end

  // round half up, then floor by shifting out the fraction
  assign rnd_sum = acc_r + iirdf1_pkg::RND_HALF;
  assign rnd_q   = rnd_sum[iirdf1_pkg::ACC_W-1:iirdf1_pkg::FRAC_BITS];

  assign ovf_pos = !rnd_q[iirdf1_pkg::RND_W-1] &&
                   (|rnd_q[iirdf1_pkg::RND_W-2:iirdf1_pkg::SAMPLE_W-1]);
  assign ovf_neg = rnd_q[iirdf1_pkg::RND_W-1] &&
                   !(&rnd_q[iirdf1_pkg::RND_W-2:iirdf1_pkg::SAMPLE_W-1]);

  always_comb begin
    if (ovf_pos) begin
      y = {1'b0, {(iirdf1_pkg::SAMPLE_W-1){1'b1}}};
    end else if (ovf_neg) begin
      y = {1'b1, {(iirdf1_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      y = rnd_q[iirdf1_pkg::SAMPLE_W-1:0];
    end
  end

  assign sat = ovf_pos || ovf_neg;

endmodule

`default_nettype wire

[hw/rtl/iir_direct_form_one_filter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// in_       input      in_valid / in_ready      in_sample_in
// out_      output     out_valid / out_ready    out_sample_out, out_saturated
// cfg_      input      cfg_wr_en                cfg_index, cfg_data
//
// Each sample takes one multiply per tap, the first in the accept cycle (IDLE state),
// the rest in the MAC state; then the ACC state closes the sum and the RND state rounds.
// A new sample is accepted only once the filter is back in IDLE after write-back.
// in_ready is high only while idle. A result waits in the output register;
// a stalled out_ready holds the next result, and its history write, back.
// Reset clears the histories, loads default coefficients and empties the output.

module iir_direct_form_one_filter #(
  parameter int FF_ORDER = 3,
  parameter int FB_ORDER = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  iirdf1_pkg::sample_t      in_sample_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output iirdf1_pkg::sample_t      out_sample_out,
  output logic                     out_saturated,
  input  logic                     cfg_wr_en,
  input  iirdf1_pkg::cfg_idx_t     cfg_index,
  input  iirdf1_pkg::coef_t        cfg_data
);

  localparam int NTAPS = 1 + FF_ORDER + FB_ORDER;
  localparam int TAP_W = $clog2(NTAPS);

  iirdf1_pkg::state_t   state_r, state_nxt;
  logic [TAP_W-1:0]     tap_r, tap_nxt;
  logic                 tap_last;
  iirdf1_pkg::sample_t  x_r;
  iirdf1_pkg::coef_t    ff_coef_r [0:FF_ORDER];
  iirdf1_pkg::coef_t    fb_coef_r [1:FB_ORDER];
  iirdf1_pkg::sample_t  in_hist_r  [0:iirdf1_pkg::HIST_DEPTH-1];
  iirdf1_pkg::sample_t  out_hist_r [0:iirdf1_pkg::HIST_DEPTH-1];
  logic                 out_valid_r, out_valid_nxt;
  iirdf1_pkg::sample_t  out_sample_r;
  logic                 out_sat_r;
  iirdf1_pkg::mac_ctl_t mac_ctl;
  iirdf1_pkg::coef_t    op_coef;
  iirdf1_pkg::sample_t  op_data;
  iirdf1_pkg::sample_t  mac_y;
  logic                 mac_sat;
  logic                 accept;
  logic                 wb;

  assign accept   = in_valid && in_ready;
  assign tap_last = (tap_r == TAP_W'(NTAPS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iirdf1_pkg::ST_IDLE: if (in_valid) state_nxt = iirdf1_pkg::ST_MAC;
      iirdf1_pkg::ST_MAC:  if (tap_last) state_nxt = iirdf1_pkg::ST_ACC;
      iirdf1_pkg::ST_ACC:  state_nxt = iirdf1_pkg::ST_RND;
      iirdf1_pkg::ST_RND:  if (!out_valid_r || out_ready) state_nxt = iirdf1_pkg::ST_IDLE;
      default:             state_nxt = iirdf1_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mac_ctl  = '0;
    wb       = 1'b0;
    tap_nxt  = tap_r;
    unique case (state_r)
      iirdf1_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        mac_ctl.mul_en  = in_valid;
        mac_ctl.acc_clr = in_valid;
        tap_nxt         = TAP_W'(1);
      end
      iirdf1_pkg::ST_MAC: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_en = 1'b1;
        tap_nxt        = tap_r + TAP_W'(1);
      end
      iirdf1_pkg::ST_ACC: begin
        mac_ctl.acc_en = 1'b1;
      end
      iirdf1_pkg::ST_RND: begin
        wb = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // operand select: current sample, input history, then output history
  always_comb begin
    op_coef = ff_coef_r[0];
    op_data = in_sample_in;
    for (int i = 1; i <= FF_ORDER; i++) begin
      if (state_r == iirdf1_pkg::ST_MAC && tap_r == TAP_W'(i)) begin
        op_coef = ff_coef_r[i];
        op_data = in_hist_r[i-1];
      end
    end
    for (int j = 1; j <= FB_ORDER; j++) begin
      if (state_r == iirdf1_pkg::ST_MAC && tap_r == TAP_W'(FF_ORDER + j)) begin
        op_coef = fb_coef_r[j];
        op_data = out_hist_r[j-1];
      end
    end
  end

  iirdf1_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .coef (op_coef),
    .data (op_data),
    .y    (mac_y),
    .sat  (mac_sat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (wb) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iirdf1_pkg::ST_IDLE;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_coef_r[0] <= iirdf1_pkg::COEF_ONE;
      for (int i = 1; i <= FF_ORDER; i++) begin
        ff_coef_r[i] <= '0;
      end
      for (int j = 1; j <= FB_ORDER; j++) begin
        fb_coef_r[j] <= '0;
      end
    end else if (cfg_wr_en) begin
      for (int i = 0; i <= FF_ORDER; i++) begin
        if (cfg_index == iirdf1_pkg::REG_FF_COEF_0 + iirdf1_pkg::cfg_idx_t'(i)) begin
          ff_coef_r[i] <= cfg_data;
        end
      end
      for (int j = 1; j <= FB_ORDER; j++) begin
        if (cfg_index == iirdf1_pkg::REG_FB_COEF_1 + iirdf1_pkg::cfg_idx_t'(j - 1)) begin
          fb_coef_r[j] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < iirdf1_pkg::HIST_DEPTH; k++) begin
        in_hist_r[k]  <= '0;
        out_hist_r[k] <= '0;
      end
    end else if (wb) begin
      for (int k = iirdf1_pkg::HIST_DEPTH - 1; k > 0; k--) begin
        in_hist_r[k]  <= in_hist_r[k-1];
        out_hist_r[k] <= out_hist_r[k-1];
      end
      in_hist_r[0]  <= x_r;
      out_hist_r[0] <= mac_y;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_sample_in;
    end
    if (wb) begin
      out_sample_r <= mac_y;
      out_sat_r    <= mac_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

endmodule

`default_nettype wire

[hw/rtl/iirdf1_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module iirdf1_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire iirdf1_pkg::sample_t out_sample_out,
  input wire logic                out_saturated
);

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  `ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

  `ASSERT_IMPL(a_sat_at_rail, clk, rst_n, out_valid && out_saturated, (out_sample_out == 24'sh7fffff || out_sample_out == 24'sh800000))

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample_out))

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind iir_direct_form_one_filter iirdf1_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out),
  .out_saturated  (out_saturated)
);

`default_nettype wire
